// ===== sv/assert_macros.svh =====
// Assertion macros used by the top RTL module of the graph center block.
// Each macro expects signals named clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/apsp_pkg.sv =====
// Package of the graph center block: widths, constants and the control
// structs passed between the sequencer and the column cells. No dependencies.
package apsp_pkg;

	localparam int MAX_NODES_DEF = 128;
	localparam int NODE_W        = 8;
	localparam int CNT_N_W       = 9;
	localparam int WEIGHT_W      = 7;
	localparam int DIST_W        = 15;
	localparam int ECC_W         = 14;

	localparam logic [DIST_W-1:0] DIST_INF = 15'h7fff;
	localparam logic [ECC_W-1:0]  ECC_MAX  = 14'h3fff;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_SOLVE = 1'b1;

	typedef struct packed {
		logic                rd_en;
		logic [NODE_W-1:0]   rd_addr;
		logic                rowk_cap;
		logic                relax_we;
		logic                clr_we;
		logic [NODE_W-1:0]   wr_addr;
		logic [DIST_W-1:0]   colk;
		logic                scan_clr;
		logic                scan_acc;
		logic                ld_we;
		logic [NODE_W-1:0]   ld_a;
		logic [NODE_W-1:0]   ld_b;
		logic [WEIGHT_W-1:0] ld_w;
		logic [CNT_N_W-1:0]  n;
	} apsp_ctrl_t;

	typedef struct packed {
		logic [DIST_W-1:0] ecc;
		logic [NODE_W-1:0] idx;
	} chain_t;

endpackage

// ===== sv/apsp_if.sv =====
// Handshake interfaces for the input items and the result items.
// Depends on apsp_pkg for the field widths.
interface apsp_in_if;
	import apsp_pkg::*;
	logic                valid;
	logic                ready;
	logic                opcode;
	logic [NODE_W-1:0]   node_a;
	logic [NODE_W-1:0]   node_b;
	logic [WEIGHT_W-1:0] weight;
	modport source (output valid, opcode, node_a, node_b, weight, input ready);
	modport sink   (input valid, opcode, node_a, node_b, weight, output ready);
endinterface

interface apsp_out_if;
	import apsp_pkg::*;
	logic              valid;
	logic              ready;
	logic              connected;
	logic [NODE_W-1:0] best_node;
	logic [ECC_W-1:0]  eccentricity;
	modport source (output valid, connected, best_node, eccentricity, input ready);
	modport sink   (input valid, connected, best_node, eccentricity, output ready);
endinterface

// ===== sv/apsp_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module apsp_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== sv/apsp_cell.sv =====
// One column cell: holds one column of the distance matrix in a RAM, relaxes
// it row by row, tracks its column maximum and forms one link of the chain.
// Depends on apsp_pkg and apsp_ram.
module apsp_cell #(
	parameter int MAX_NODES = apsp_pkg::MAX_NODES_DEF,
	parameter int IDX       = 0
) (
	input  logic                            clk,
	input  apsp_pkg::apsp_ctrl_t            ctrl,
	input  apsp_pkg::chain_t                chain_in,
	output apsp_pkg::chain_t                chain_out,
	output logic [apsp_pkg::DIST_W-1:0]     rdata
);
	import apsp_pkg::*;

	localparam int AW = $clog2(MAX_NODES);
	localparam logic [NODE_W-1:0] ID = NODE_W'(IDX);

	logic              active;
	logic [DIST_W-1:0] rowk_q, own_s2, ecc_q;
	logic [DIST_W:0]   sum;
	logic [DIST_W-1:0] relax_val, new_val;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [DIST_W-1:0] wdata;
	chain_t            chain_q;

	assign active = {1'b0, ID} < ctrl.n;
	assign sum = {1'b0, ctrl.colk} + {1'b0, rowk_q};
	assign relax_val = (sum > {1'b0, DIST_INF}) ? DIST_INF : sum[DIST_W-1:0];
	assign new_val = (relax_val < own_s2) ? relax_val : own_s2;

	always_comb begin
		we    = 1'b0;
		waddr = ctrl.wr_addr[AW-1:0];
		wdata = new_val;
		if (ctrl.clr_we) begin
			we    = 1'b1;
			wdata = (ctrl.wr_addr == ID) ? '0 : DIST_INF;
		end else if (ctrl.relax_we && active) begin
			we = 1'b1;
		end else if (ctrl.ld_we && ctrl.ld_b == ID) begin
			we    = 1'b1;
			waddr = ctrl.ld_a[AW-1:0];
			wdata = DIST_W'(ctrl.ld_w);
		end else if (ctrl.ld_we && ctrl.ld_a == ID) begin
			we    = 1'b1;
			waddr = ctrl.ld_b[AW-1:0];
			wdata = DIST_W'(ctrl.ld_w);
		end
	end

	apsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (ctrl.rd_en),
		.raddr (ctrl.rd_addr[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		own_s2 <= rdata;
		if (ctrl.rowk_cap) begin
			rowk_q <= rdata;
		end
		if (ctrl.scan_clr) begin
			ecc_q <= '0;
		end else if (ctrl.scan_acc && rdata > ecc_q) begin
			ecc_q <= rdata;
		end
		if (active && ecc_q < chain_in.ecc) begin
			chain_q <= '{ecc: ecc_q, idx: ID};
		end else begin
			chain_q <= chain_in;
		end
	end

	assign chain_out = chain_q;
endmodule

// ===== sv/all_pairs_shortest_path_center.sv =====
// Graph center by all-pairs shortest paths: column cells, sequencer, result register.
// Depends on apsp_pkg, apsp_if, apsp_cell and assert_macros.svh.
//
// Edge loads are taken one per cycle while the block is idle. A solve item
// holds off input while the matrix is relaxed one row per cycle across all
// column cells at once, one pivot after another for the n nodes in use. Then
// a scan finds the column maxima, the best candidate moves down the cell
// chain, the result is latched once any earlier result has been taken, and
// a clearing pass rewrites the matrix to its cleared form while the result
// is offered. The same clearing pass runs after reset before the first item.
`include "assert_macros.svh"

module all_pairs_shortest_path_center #(
	parameter int MAX_NODES = apsp_pkg::MAX_NODES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [apsp_pkg::NODE_W-1:0] cfg_wdata,
	apsp_in_if.sink                   item,
	apsp_out_if.source                result
);
	import apsp_pkg::*;

	localparam int IW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 4);

	typedef enum logic [2:0] {IDLE, RELAX, SCAN, CHAIN, HOLD, CLEAR} state_t;

	state_t             state_q;
	logic [CW-1:0]      cnt_q;
	logic [IW-1:0]      k_q;
	logic [NODE_W-1:0]  cfg_q;
	logic [CNT_N_W-1:0] n;
	logic [CW-1:0]      n_c;
	logic               v_s1, v_s2;
	logic [NODE_W-1:0]  a_s1, a_s2;
	logic [DIST_W-1:0]  colk_s2;
	logic               out_v_q, conn_q;
	logic [NODE_W-1:0]  best_q;
	logic [ECC_W-1:0]   ecc_q;
	logic               take, ld_ok, free_out;
	apsp_ctrl_t         ctrl;
	chain_t             link [MAX_NODES+1];
	logic [DIST_W-1:0]  rd_all [MAX_NODES];
	chain_t             best;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= NODE_W'(1);
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (cfg_q == '0) begin
			n = CNT_N_W'(1);
		end else if ({1'b0, cfg_q} > CNT_N_W'(MAX_NODES)) begin
			n = CNT_N_W'(MAX_NODES);
		end else begin
			n = {1'b0, cfg_q};
		end
	end
	assign n_c = CW'(n);

	assign item.ready = (state_q == IDLE);
	assign take = item.valid && item.ready;
	assign ld_ok = item.node_a != '0 && item.node_b != '0 &&
		{1'b0, item.node_a} <= n && {1'b0, item.node_b} <= n &&
		item.node_a != item.node_b;
	assign free_out = !out_v_q || result.ready;

	always_comb begin
		ctrl          = '0;
		ctrl.n        = n;
		ctrl.colk     = colk_s2;
		ctrl.relax_we = v_s2;
		ctrl.wr_addr  = (state_q == CLEAR) ? NODE_W'(cnt_q) : a_s2;
		ctrl.clr_we   = (state_q == CLEAR);
		ctrl.ld_we    = take && item.opcode == OP_LOAD && ld_ok;
		ctrl.ld_a     = item.node_a - NODE_W'(1);
		ctrl.ld_b     = item.node_b - NODE_W'(1);
		ctrl.ld_w     = item.weight;
		case (state_q)
			RELAX: begin
				ctrl.rd_en    = (cnt_q <= n_c);
				ctrl.rd_addr  = (cnt_q == '0) ? NODE_W'(k_q) : NODE_W'(cnt_q - CW'(1));
				ctrl.rowk_cap = (cnt_q == CW'(1));
			end
			SCAN: begin
				ctrl.rd_en    = (cnt_q < n_c);
				ctrl.rd_addr  = NODE_W'(cnt_q);
				ctrl.scan_clr = (cnt_q == '0);
				ctrl.scan_acc = (cnt_q != '0);
			end
			default: begin
			end
		endcase
	end

	assign link[0] = '{ecc: DIST_INF, idx: '0};

	for (genvar j = 0; j < MAX_NODES; j++) begin : g_cell
		apsp_cell #(.MAX_NODES(MAX_NODES), .IDX(j)) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.chain_in  (link[j]),
			.chain_out (link[j+1]),
			.rdata     (rd_all[j])
		);
	end

	assign best = link[MAX_NODES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == RELAX) && cnt_q != '0 && cnt_q <= n_c;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		a_s1    <= NODE_W'(cnt_q - CW'(1));
		a_s2    <= a_s1;
		colk_s2 <= rd_all[k_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLEAR;
			cnt_q   <= '0;
			k_q     <= '0;
			out_v_q <= 1'b0;
			conn_q  <= 1'b0;
			best_q  <= '0;
			ecc_q   <= '0;
		end else begin
			if (result.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (take && item.opcode == OP_SOLVE) begin
						state_q <= RELAX;
						cnt_q   <= '0;
						k_q     <= '0;
					end
				end
				RELAX: begin
					if (cnt_q == n_c + CW'(2)) begin
						cnt_q <= '0;
						if (k_q == IW'(n - CNT_N_W'(1))) begin
							state_q <= SCAN;
						end else begin
							k_q <= k_q + IW'(1);
						end
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				SCAN: begin
					if (cnt_q == n_c) begin
						state_q <= CHAIN;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				CHAIN: begin
					if (cnt_q == CW'(MAX_NODES)) begin
						state_q <= HOLD;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				HOLD: begin
					if (free_out) begin
						out_v_q <= 1'b1;
						state_q <= CLEAR;
						cnt_q   <= '0;
						if (best.ecc == DIST_INF) begin
							conn_q <= 1'b0;
							best_q <= '0;
							ecc_q  <= '0;
						end else begin
							conn_q <= 1'b1;
							best_q <= best.idx + NODE_W'(1);
							ecc_q  <= (best.ecc > DIST_W'(ECC_MAX)) ? ECC_MAX :
								best.ecc[ECC_W-1:0];
						end
					end
				end
				CLEAR: begin
					if (cnt_q == CW'(MAX_NODES - 1)) begin
						state_q <= IDLE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign result.valid        = out_v_q;
	assign result.connected    = conn_q;
	assign result.best_node    = best_q;
	assign result.eccentricity = ecc_q;

	`ASSERT_IMPL(a_no_load_in_relax, v_s2, !ctrl.ld_we && state_q != IDLE)
	`ASSERT_IMPL(a_relax_row_range, v_s2, {1'b0, a_s2} < n)
	`ASSERT_NEXT(a_result_latched, state_q == HOLD && free_out, out_v_q && state_q == CLEAR)
endmodule

// ===== tb/apsp_center_checker.sv =====
// Checker for the graph center block: watches the register port and both channels,
// keeps its own distance matrix and predicts each solve answer. Depends on apsp_pkg, apsp_if.
`timescale 1ns / 100ps

module apsp_center_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [apsp_pkg::NODE_W-1:0] cfg_wdata,
	apsp_in_if                          item,
	apsp_out_if                         result,
	output int                          fail_count,
	output int                          pending
);
	import apsp_pkg::*;

	localparam int NODES = MAX_NODES_DEF;

	typedef struct {
		logic              connected;
		logic [NODE_W-1:0] best_node;
		logic [ECC_W-1:0]  eccentricity;
	} center_t;

	logic [DIST_W-1:0] dmat [NODES][NODES];
	logic [NODE_W-1:0] node_count;
	center_t           answers [$];

	task automatic clear_matrix();
		for (int i = 0; i < NODES; i++) begin
			for (int j = 0; j < NODES; j++) begin
				dmat[i][j] = (i == j) ? '0 : DIST_INF;
			end
		end
	endtask

	function automatic int nodes_in_use();
		int n;
		n = node_count;
		if (n == 0) n = 1;
		if (n > NODES) n = NODES;
		return n;
	endfunction

	task automatic apply_edge(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b,
			input logic [WEIGHT_W-1:0] w);
		int n;
		n = nodes_in_use();
		if (a == 0 || b == 0 || a > n || b > n || a == b) return;
		dmat[a-1][b-1] = DIST_W'(w);
		dmat[b-1][a-1] = DIST_W'(w);
	endtask

	task automatic solve_center();
		int      n;
		int      s;
		int      ecc;
		int      best_ecc;
		int      best_i;
		center_t ans;
		n = nodes_in_use();
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < n; i++) begin
				for (int j = 0; j < n; j++) begin
					s = int'(dmat[i][k]) + int'(dmat[k][j]);
					if (s > int'(DIST_INF)) s = int'(DIST_INF);
					if (int'(dmat[i][j]) > s) dmat[i][j] = DIST_W'(s);
				end
			end
		end
		best_ecc = int'(DIST_INF);
		best_i = 0;
		for (int i = 0; i < n; i++) begin
			ecc = 0;
			for (int j = 0; j < n; j++) begin
				if (int'(dmat[i][j]) > ecc) ecc = dmat[i][j];
			end
			if (ecc < best_ecc) begin
				best_ecc = ecc;
				best_i = i;
			end
		end
		if (best_ecc >= int'(DIST_INF)) begin
			ans = '{1'b0, '0, '0};
		end else begin
			ans.connected = 1'b1;
			ans.best_node = NODE_W'(best_i + 1);
			ans.eccentricity = (best_ecc > int'(ECC_MAX)) ? ECC_MAX : ECC_W'(best_ecc);
		end
		answers.push_back(ans);
		clear_matrix();
	endtask

	always @(posedge clk or negedge arst_n) begin
		center_t exp_ans;
		if (!arst_n) begin
			node_count = 1;
			clear_matrix();
			answers.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) node_count = cfg_wdata;
			if (item.valid && item.ready) begin
				if (item.opcode == OP_SOLVE) solve_center();
				else apply_edge(item.node_a, item.node_b, item.weight);
			end
			if (result.valid && result.ready) begin
				if (answers.size() == 0) begin
					$error("unexpected result transfer");
					fail_count++;
				end else begin
					exp_ans = answers.pop_front();
					if (result.connected !== exp_ans.connected) begin
						$error("connected: expected %0d, got %0d", exp_ans.connected,
							result.connected);
						fail_count++;
					end
					if (result.best_node !== exp_ans.best_node) begin
						$error("best_node: expected %0d, got %0d", exp_ans.best_node,
							result.best_node);
						fail_count++;
					end
					if (result.eccentricity !== exp_ans.eccentricity) begin
						$error("eccentricity: expected %0d, got %0d", exp_ans.eccentricity,
							result.eccentricity);
						fail_count++;
					end
				end
			end
		end
		pending = answers.size();
	end

endmodule

// ===== tb/all_pairs_shortest_path_center_tb.sv =====
// Top of the graph center testbench: clock, reset, register writes, edge and
// solve stimulus, result back-pressure and the verdict. Depends on apsp_pkg,
// apsp_if, the block and apsp_center_checker.
`timescale 1ns / 100ps

module all_pairs_shortest_path_center_tb;
	import apsp_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE      = 300;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [NODE_W-1:0] cfg_wdata = '0;
	int                fail_count;
	int                pending;
	int                cycles = 0;
	int                loads_sent = 0;
	bit                calm_send = 1'b0;
	bit                calm_recv = 1'b0;
	bit                hold_req = 1'b0;

	apsp_in_if  in_ch ();
	apsp_out_if out_ch ();

	all_pairs_shortest_path_center dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (in_ch),
		.result    (out_ch)
	);

	apsp_center_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item       (in_ch),
		.result     (out_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[all_pairs_shortest_path_center] ERROR");
			$finish;
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.opcode = OP_LOAD;
		in_ch.node_a = '0;
		in_ch.node_b = '0;
		in_ch.weight = '0;
		out_ch.ready = 1'b0;
	end

	// Result side: random stalls per transfer, with one long hold-off on request.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_req = 1'b0;
			end
			stall = calm_recv ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
		end
	end

	task automatic send(input logic op, input logic [NODE_W-1:0] a,
			input logic [NODE_W-1:0] b, input logic [WEIGHT_W-1:0] w);
		int gap;
		gap = calm_send ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= op;
		in_ch.node_a <= a;
		in_ch.node_b <= b;
		in_ch.weight <= w;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if (op == OP_LOAD) loads_sent++;
	endtask

	task automatic edge_load(input int a, input int b, input int w);
		send(OP_LOAD, NODE_W'(a), NODE_W'(b), WEIGHT_W'(w));
	endtask

	task automatic solve_item();
		send(OP_SOLVE, NODE_W'($urandom), NODE_W'($urandom), WEIGHT_W'($urandom));
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_node_count(input int v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= NODE_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic int eff_nodes(input int v);
		if (v == 0) return 1;
		if (v > MAX_NODES_DEF) return MAX_NODES_DEF;
		return v;
	endfunction

	// Mostly a spanning tree plus extra edges; sometimes a sparse random graph,
	// with a sprinkling of out-of-range endpoints and self loops.
	task automatic graph_phase(input int n);
		int extra;
		int a;
		int b;
		if ($urandom_range(0, 3) != 0) begin
			for (int v = 2; v <= n; v++) edge_load(v, $urandom_range(1, v - 1),
				$urandom_range(0, 127));
		end
		extra = $urandom_range(0, n + 2);
		for (int e = 0; e < extra; e++) begin
			case ($urandom_range(0, 9))
				0: begin
					a = $urandom_range(0, 255);
					b = $urandom_range(0, 255);
				end
				1: begin
					a = $urandom_range(1, n);
					b = a;
				end
				default: begin
					a = $urandom_range(1, n);
					b = $urandom_range(1, n);
				end
			endcase
			edge_load(a, b, $urandom_range(0, 127));
		end
		solve_item();
	endtask

	initial begin
		int cnt;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		calm_send = 1'b1;
		calm_recv = 1'b1;
		solve_item();
		set_node_count(0);
		edge_load(1, 1, 5);
		solve_item();
		set_node_count(3);
		edge_load(1, 2, 0);
		edge_load(2, 3, 127);
		edge_load(1, 3, 100);
		edge_load(1, 3, 127);
		edge_load(0, 2, 9);
		edge_load(4, 1, 9);
		edge_load(2, 2, 9);
		solve_item();
		solve_item();
		set_node_count(2);
		edge_load(2, 1, 1);
		solve_item();
		calm_send = 1'b0;
		calm_recv = 1'b0;

		set_node_count(255);
		for (int v = 2; v <= MAX_NODES_DEF; v++) edge_load(v - 1, v, 127);
		edge_load(128, 0, 3);
		edge_load(255, 1, 3);
		solve_item();
		set_node_count(128);
		graph_phase(128);

		set_node_count(5);
		hold_req = 1'b1;
		graph_phase(5);
		graph_phase(5);
		graph_phase(5);
		graph_phase(5);

		while (loads_sent < 600) begin
			calm_send = ($urandom_range(0, 3) == 0);
			calm_recv = ($urandom_range(0, 3) == 0);
			cnt = $urandom_range(0, 12);
			set_node_count(cnt);
			graph_phase(eff_nodes(cnt));
			if ($urandom_range(0, 1)) graph_phase(eff_nodes(cnt));
		end

		drain();
		if (fail_count == 0) begin
			$display("[all_pairs_shortest_path_center] OK");
		end else begin
			$display("[all_pairs_shortest_path_center] ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/apsp_pkg.sv
sv/apsp_if.sv
sv/apsp_ram.sv
sv/apsp_cell.sv
sv/all_pairs_shortest_path_center.sv
tb/apsp_center_checker.sv
tb/all_pairs_shortest_path_center_tb.sv
